// ===== src/lhm_pkg.sv =====
package lhm_pkg;

   localparam int unsigned LIMIT_W = 16;
   localparam int unsigned RUN_W   = 16;
   localparam int unsigned KIND_W  = 3;
   localparam int unsigned TIME_W  = 32;
   localparam int unsigned CNT_W   = 32;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd3;
   localparam logic [RUN_W-1:0]   RUN_MAX     = 16'hFFFF;

   typedef logic [KIND_W-1:0] fail_kind_type;

   localparam fail_kind_type KIND_OK      = 3'd0;
   localparam fail_kind_type KIND_TIMEOUT = 3'd1;
   localparam fail_kind_type KIND_CRC     = 3'd2;
   localparam fail_kind_type KIND_EXCEPT  = 3'd3;
   localparam fail_kind_type KIND_OTHER   = 3'd4;

   localparam logic CMD_SUCCESS = 1'b0;
   localparam logic CMD_FAILURE = 1'b1;

   typedef enum logic [1:0] {
      LINK_INIT     = 2'd0,
      LINK_ONLINE   = 2'd1,
      LINK_DEGRADED = 2'd2,
      LINK_OFFLINE  = 2'd3
   } health_state_type;

   typedef struct packed {
      health_state_type   health_state;
      logic [RUN_W-1:0]   fail_run;
      logic [CNT_W-1:0]   seq_number;
      logic               data_valid;
      logic               data_stale;
      fail_kind_type      latest_status;
      logic [TIME_W-1:0]  success_time;
      logic [CNT_W-1:0]   ok_count;
      logic [CNT_W-1:0]   timeout_count;
      logic [CNT_W-1:0]   crc_count;
      logic [CNT_W-1:0]   except_count;
      logic [CNT_W-1:0]   misc_count;
   } lhm_status_type;

   typedef struct packed {
      logic                        update;
      logic                        command;
      fail_kind_type               fail_kind;
      logic [TIME_W-1:0]           now_ms;
   } lhm_event_type;

endpackage

// ===== src/lhm_req_if.sv =====
interface lhm_req_if;
   logic                             valid;
   logic                             ready;
   logic                             command;
   logic [lhm_pkg::KIND_W-1:0]       fail_kind;
   logic [lhm_pkg::TIME_W-1:0]       now_ms;

   modport source (output valid, output command, output fail_kind, output now_ms,
                   input ready);
   modport sink   (input valid, input command, input fail_kind, input now_ms,
                   output ready);
endinterface

// ===== src/lhm_rsp_if.sv =====
interface lhm_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [1:0]                     health_state;
   logic [lhm_pkg::RUN_W-1:0]      fail_run;
   logic [lhm_pkg::CNT_W-1:0]      seq_number;
   logic                           data_valid;
   logic                           data_stale;
   logic [lhm_pkg::KIND_W-1:0]     latest_status;
   logic [lhm_pkg::TIME_W-1:0]     success_time;
   logic [lhm_pkg::CNT_W-1:0]      ok_count;
   logic [lhm_pkg::CNT_W-1:0]      timeout_count;
   logic [lhm_pkg::CNT_W-1:0]      crc_count;
   logic [lhm_pkg::CNT_W-1:0]      except_count;
   logic [lhm_pkg::CNT_W-1:0]      misc_count;

   modport source (output valid, output health_state, output fail_run, output seq_number,
                   output data_valid, output data_stale, output latest_status,
                   output success_time, output ok_count, output timeout_count,
                   output crc_count, output except_count, output misc_count,
                   input ready);
   modport sink   (input valid, input health_state, input fail_run, input seq_number,
                   input data_valid, input data_stale, input latest_status,
                   input success_time, input ok_count, input timeout_count,
                   input crc_count, input except_count, input misc_count,
                   output ready);
endinterface

// ===== src/link_health_monitor.sv =====
// Health monitor for a polled field-bus link.
// Each beat on the req_chan channel reports one poll: success, or failure
// with a failure kind, plus the millisecond timestamp of the poll.
// For every request beat exactly one beat appears on rsp_chan, carrying the
// link state, failure run, sequence number, flags, latest status, last
// success time and the five per-kind counters as they stand after the poll.
// The request is captured in an input register; the state update is then
// computed and written into the response register when that register is
// empty or its beat is taken. One request can be accepted every cycle while
// responses are taken; the throughput is set by the combinational counter
// and compare logic between the two registers. The offline limit is written
// through csr_wr_en and csr_wr_data; the user must write it only while no
// poll is in flight, which the block itself does not enforce. It resets to
// 3, and a limit of 0 never goes offline. A synchronous reset clears all
// counters, flags and the link state (init) and empties both registers.
// When the receiver holds rsp_chan.ready low, the response register holds
// its beat, one more request may wait in the input register, and then
// req_chan.ready drops until the response is taken.
module link_health_monitor (
   input  logic                          clock,
   input  logic                          reset,
   lhm_req_if.sink                       req_chan,
   lhm_rsp_if.source                     rsp_chan,
   input  logic                          csr_wr_en,
   input  logic [lhm_pkg::LIMIT_W-1:0]   csr_wr_data
);

   logic                         in_valid_ff;
   logic                         in_cmd_ff;
   lhm_pkg::fail_kind_type       in_kind_ff;
   logic [lhm_pkg::TIME_W-1:0]   in_time_ff;
   logic                         out_valid_ff;
   lhm_pkg::lhm_status_type      out_status_ff;
   lhm_pkg::lhm_status_type      status_next;
   lhm_pkg::lhm_event_type       event_beat;
   logic                         out_free;
   logic                         advance;
   logic                         req_fire;

   assign out_free = !out_valid_ff || rsp_chan.ready;
   assign advance  = in_valid_ff && out_free;
   assign req_chan.ready = !in_valid_ff || out_free;
   assign req_fire = req_chan.valid && req_chan.ready;

   assign event_beat.update    = advance;
   assign event_beat.command   = in_cmd_ff;
   assign event_beat.fail_kind = in_kind_ff;
   assign event_beat.now_ms    = in_time_ff;

   lhm_tracker u_tracker (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .event_beat  (event_beat),
      .status_next (status_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_chan.ready) begin
            in_valid_ff <= req_chan.valid;
         end
         if (out_free) begin
            out_valid_ff <= in_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_cmd_ff  <= req_chan.command;
         in_kind_ff <= req_chan.fail_kind;
         in_time_ff <= req_chan.now_ms;
      end
      if (advance) begin
         out_status_ff <= status_next;
      end
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.health_state  = out_status_ff.health_state;
   assign rsp_chan.fail_run      = out_status_ff.fail_run;
   assign rsp_chan.seq_number    = out_status_ff.seq_number;
   assign rsp_chan.data_valid    = out_status_ff.data_valid;
   assign rsp_chan.data_stale    = out_status_ff.data_stale;
   assign rsp_chan.latest_status = out_status_ff.latest_status;
   assign rsp_chan.success_time  = out_status_ff.success_time;
   assign rsp_chan.ok_count      = out_status_ff.ok_count;
   assign rsp_chan.timeout_count = out_status_ff.timeout_count;
   assign rsp_chan.crc_count     = out_status_ff.crc_count;
   assign rsp_chan.except_count  = out_status_ff.except_count;
   assign rsp_chan.misc_count    = out_status_ff.misc_count;

endmodule

// ===== src/lhm_tracker.sv =====
module lhm_tracker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [lhm_pkg::LIMIT_W-1:0]        csr_wr_data,
   input  lhm_pkg::lhm_event_type             event_beat,
   output lhm_pkg::lhm_status_type            status_next
);

   localparam int unsigned SLOTS = 5;

   logic [lhm_pkg::LIMIT_W-1:0]  limit_ff;
   lhm_pkg::health_state_type    mode_ff, mode_in;
   logic [lhm_pkg::RUN_W-1:0]    run_ff, run_in;
   logic [lhm_pkg::CNT_W-1:0]    seq_ff, seq_in;
   logic                         valid_ff, valid_in;
   logic                         stale_ff, stale_in;
   lhm_pkg::fail_kind_type       status_ff, status_in;
   logic [lhm_pkg::TIME_W-1:0]   ok_time_ff, ok_time_in;
   logic [lhm_pkg::CNT_W-1:0]    cnt_ff [SLOTS];
   logic [lhm_pkg::CNT_W-1:0]    cnt_in [SLOTS];
   logic [SLOTS-1:0]             hit;

   always_comb begin
      hit = '0;
      if (event_beat.command == lhm_pkg::CMD_SUCCESS) begin
         hit[0] = 1'b1;
      end else begin
         case (event_beat.fail_kind)
            lhm_pkg::KIND_TIMEOUT: hit[1] = 1'b1;
            lhm_pkg::KIND_CRC:     hit[2] = 1'b1;
            lhm_pkg::KIND_EXCEPT:  hit[3] = 1'b1;
            default:               hit[4] = 1'b1;
         endcase
      end
      for (int i = 0; i < SLOTS; i++) begin
         cnt_in[i] = cnt_ff[i] + {{(lhm_pkg::CNT_W-1){1'b0}}, hit[i]};
      end
   end

   always_comb begin
      mode_in    = mode_ff;
      run_in     = run_ff;
      seq_in     = seq_ff;
      valid_in   = valid_ff;
      stale_in   = stale_ff;
      status_in  = status_ff;
      ok_time_in = ok_time_ff;
      if (event_beat.command == lhm_pkg::CMD_SUCCESS) begin
         seq_in     = seq_ff + {{(lhm_pkg::CNT_W-1){1'b0}}, 1'b1};
         ok_time_in = event_beat.now_ms;
         valid_in   = 1'b1;
         stale_in   = 1'b0;
         status_in  = lhm_pkg::KIND_OK;
         mode_in    = lhm_pkg::LINK_ONLINE;
         run_in     = '0;
      end else begin
         status_in = event_beat.fail_kind;
         stale_in  = 1'b1;
         if (run_ff != lhm_pkg::RUN_MAX) begin
            run_in = run_ff + {{(lhm_pkg::RUN_W-1){1'b0}}, 1'b1};
         end
         if (limit_ff != '0 && run_in >= limit_ff) begin
            mode_in = lhm_pkg::LINK_OFFLINE;
         end else begin
            mode_in = lhm_pkg::LINK_DEGRADED;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff   <= lhm_pkg::LIMIT_RESET;
         mode_ff    <= lhm_pkg::LINK_INIT;
         run_ff     <= '0;
         seq_ff     <= '0;
         valid_ff   <= 1'b0;
         stale_ff   <= 1'b0;
         status_ff  <= lhm_pkg::KIND_OK;
         ok_time_ff <= '0;
         for (int i = 0; i < SLOTS; i++) begin
            cnt_ff[i] <= '0;
         end
      end else begin
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
         if (event_beat.update) begin
            mode_ff    <= mode_in;
            run_ff     <= run_in;
            seq_ff     <= seq_in;
            valid_ff   <= valid_in;
            stale_ff   <= stale_in;
            status_ff  <= status_in;
            ok_time_ff <= ok_time_in;
            for (int i = 0; i < SLOTS; i++) begin
               cnt_ff[i] <= cnt_in[i];
            end
         end
      end
   end

   always_comb begin
      status_next.health_state  = mode_in;
      status_next.fail_run      = run_in;
      status_next.seq_number    = seq_in;
      status_next.data_valid    = valid_in;
      status_next.data_stale    = stale_in;
      status_next.latest_status = status_in;
      status_next.success_time  = ok_time_in;
      status_next.ok_count      = cnt_in[0];
      status_next.timeout_count = cnt_in[1];
      status_next.crc_count     = cnt_in[2];
      status_next.except_count  = cnt_in[3];
      status_next.misc_count    = cnt_in[4];
   end

endmodule
